FILE: rtl/kre_pkg.sv
// Shared constants, register indexes and packer handshake types for the
// keyed run-length row encoder. No dependencies.
`timescale 1ns / 1ps

package kre_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_ROWS   = 4096;
  localparam int RUN_CAP    = 126;

  localparam int CFG_W      = 13;
  localparam int KEY_W      = 9;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int RUN_W      = $clog2(RUN_CAP + 1);
  localparam int ADDR_W     = $clog2(RUN_CAP);
  localparam int WORD_BYTES = 8;
  localparam int WORD_W     = WORD_BYTES * PIX_W;
  localparam int FILL_W     = $clog2(WORD_BYTES);
  localparam int CNT_W      = FILL_W + 1;
  localparam int TOTAL_W    = 25;
  localparam int IDX_W      = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [IDX_W-1:0] REG_KEY_VALUE = 2'd2;

  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 13'd1;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 13'd1;
  localparam logic [KEY_W-1:0] KEY_VALUE_RST = 9'h1FF;

  // Sequencer to packer
  typedef struct packed {
    logic             push;
    logic [PIX_W-1:0] data;
    logic             mark;   // completed word closes the frame
    logic             flush;  // frame end: emit partial word, restart totals
  } pack_cmd_t;

  // Packer to sequencer
  typedef struct packed {
    logic push_ok;
    logic flush_ok;
  } pack_sts_t;

endpackage

FILE: rtl/keyed_rle_row_encoder.sv
// Keyed run-length row encoder top level: configuration registers, sequencer,
// literal RAM and byte packer. Depends on kre_pkg, kre_seq, kre_ram, kre_pack.
`timescale 1ns / 1ps

// Usage
//   Pixels enter in raster order on the in channel (valid/ready, pixel_i).
//   Encoded bytes leave eight to a word on the out channel, first byte in the
//   low bits, with byte_count_o, frame_end_o and the running encoded_length_o.
//   Registers row_width (0), row_count (1), key_value (2): cfg channel, always
//   ready. The user writes them only while the encoder is idle; not enforced.
//   Flow: a pixel that closes no run passes the idle and append states. Closing
//   a run pushes each encoded byte into the packer (1 for a key run, length
//   + 1 for a literal run), and a frame end adds a flush of the final partial
//   word. The shared byte packer takes one byte per cycle unless a receiver
//   stall holds it; literals come back from a 126-entry RAM one read per cycle.
//   Output: a word is valid in the cycle after its last byte or flush is taken.
//   Reset: registers return to width 1, count 1, no key; run, position and
//   packing state clear. No clearing pass is needed.
//   Receiver stall: the completed word holds in the output register; packing
//   continues until the next word completes, then the sequencer waits.
module keyed_rle_row_encoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [kre_pkg::PIX_W-1:0]         pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [kre_pkg::WORD_W-1:0]        packed_bytes_o,
  output logic [kre_pkg::CNT_W-1:0]         byte_count_o,
  output logic                              frame_end_o,
  output logic [kre_pkg::TOTAL_W-1:0]       encoded_length_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kre_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [kre_pkg::CFG_W-1:0]         cfg_data_i
);

  logic [kre_pkg::CFG_W-1:0]  row_width_q;
  logic [kre_pkg::CFG_W-1:0]  row_count_q;
  logic [kre_pkg::KEY_W-1:0]  key_value_q;

  kre_pkg::pack_cmd_t         pack_cmd;
  kre_pkg::pack_sts_t         pack_sts;
  logic                       ram_we;
  logic [kre_pkg::ADDR_W-1:0] ram_wa;
  logic [kre_pkg::PIX_W-1:0]  ram_wd;
  logic                       ram_re;
  logic [kre_pkg::ADDR_W-1:0] ram_ra;
  logic [kre_pkg::PIX_W-1:0]  ram_rd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= kre_pkg::ROW_WIDTH_RST;
      row_count_q <= kre_pkg::ROW_COUNT_RST;
      key_value_q <= kre_pkg::KEY_VALUE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        kre_pkg::REG_ROW_WIDTH: row_width_q <= cfg_data_i;
        kre_pkg::REG_ROW_COUNT: row_count_q <= cfg_data_i;
        kre_pkg::REG_KEY_VALUE: key_value_q <= cfg_data_i[kre_pkg::KEY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  kre_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_i     (pixel_i),
    .row_width_i (row_width_q),
    .row_count_i (row_count_q),
    .key_value_i (key_value_q),
    .cmd_o       (pack_cmd),
    .sts_i       (pack_sts),
    .ram_we_o    (ram_we),
    .ram_wa_o    (ram_wa),
    .ram_wd_o    (ram_wd),
    .ram_re_o    (ram_re),
    .ram_ra_o    (ram_ra),
    .ram_rd_i    (ram_rd)
  );

  kre_ram #(
    .WIDTH (kre_pkg::PIX_W),
    .DEPTH (kre_pkg::RUN_CAP)
  ) u_lit_ram (
    .clk_i (clk_i),
    .we_i  (ram_we),
    .wa_i  (ram_wa),
    .wd_i  (ram_wd),
    .re_i  (ram_re),
    .ra_i  (ram_ra),
    .rd_o  (ram_rd)
  );

  kre_pack u_pack (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (pack_cmd),
    .sts_o            (pack_sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .packed_bytes_o   (packed_bytes_o),
    .byte_count_o     (byte_count_o),
    .frame_end_o      (frame_end_o),
    .encoded_length_o (encoded_length_o)
  );

  // Only the frame's final word may be partial
  a_partial_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_count_o != kre_pkg::CNT_W'(kre_pkg::WORD_BYTES)) |-> frame_end_o)
    else $error("partial word without frame end");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_count_o != '0) &&
                    (byte_count_o <= kre_pkg::CNT_W'(kre_pkg::WORD_BYTES)))
    else $error("byte count out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("encoder ready right after a pixel transfer");

endmodule

FILE: rtl/kre_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wa_i,
  input  logic [WIDTH-1:0]         wd_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] ra_i,
  output logic [WIDTH-1:0]         rd_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    if (re_i) begin
      rd_q <= mem_q[ra_i];
    end
  end

  assign rd_o = rd_q;

endmodule

FILE: rtl/kre_pack.sv
// Byte packer: gathers encoded bytes into 64-bit words, keeps the frame byte
// total and holds the output register. Depends on kre_pkg.
`timescale 1ns / 1ps

module kre_pack (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  kre_pkg::pack_cmd_t               cmd_i,
  output kre_pkg::pack_sts_t               sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [kre_pkg::WORD_W-1:0]       packed_bytes_o,
  output logic [kre_pkg::CNT_W-1:0]        byte_count_o,
  output logic                             frame_end_o,
  output logic [kre_pkg::TOTAL_W-1:0]      encoded_length_o
);

  logic [kre_pkg::WORD_W-1:0]  pack_q;
  logic [kre_pkg::FILL_W-1:0]  fill_q;
  logic [kre_pkg::TOTAL_W-1:0] total_q;
  logic                        out_valid_q;
  logic [kre_pkg::WORD_W-1:0]  out_word_q;
  logic [kre_pkg::CNT_W-1:0]   out_cnt_q;
  logic                        out_last_q;
  logic [kre_pkg::TOTAL_W-1:0] out_len_q;

  logic                        slot_free;
  logic                        fill_full;
  logic                        do_push;
  logic                        do_flush;
  logic                        load_full;
  logic                        load_part;
  logic [kre_pkg::WORD_W-1:0]  word_nx;
  logic [kre_pkg::TOTAL_W-1:0] total_inc;

  always_comb begin
    slot_free = !out_valid_q || out_ready_i;
    fill_full = (fill_q == kre_pkg::FILL_W'(kre_pkg::WORD_BYTES - 1));
    sts_o.push_ok  = !fill_full || slot_free;
    sts_o.flush_ok = (fill_q == '0) || slot_free;
    do_push   = cmd_i.push && sts_o.push_ok;
    do_flush  = !cmd_i.push && cmd_i.flush && sts_o.flush_ok;
    load_full = do_push && fill_full;
    load_part = do_flush && (fill_q != '0);
    total_inc = total_q + kre_pkg::TOTAL_W'(1);
    word_nx   = pack_q;
    word_nx[{fill_q, 3'b000} +: kre_pkg::PIX_W] = cmd_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q      <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (do_push) begin
        total_q <= total_inc;
        if (fill_full) begin
          pack_q      <= '0;
          fill_q      <= '0;
          out_valid_q <= 1'b1;
        end else begin
          pack_q <= word_nx;
          fill_q <= fill_q + kre_pkg::FILL_W'(1);
        end
      end else if (do_flush) begin
        pack_q  <= '0;
        fill_q  <= '0;
        total_q <= '0;
        if (load_part) begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  // Output payload: loaded only with a new word
  always_ff @(posedge clk_i) begin
    if (load_full) begin
      out_word_q <= word_nx;
      out_cnt_q  <= kre_pkg::CNT_W'(kre_pkg::WORD_BYTES);
      out_last_q <= cmd_i.mark;
      out_len_q  <= total_inc;
    end else if (load_part) begin
      out_word_q <= pack_q;
      out_cnt_q  <= {1'b0, fill_q};
      out_last_q <= 1'b1;
      out_len_q  <= total_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign packed_bytes_o   = out_word_q;
  assign byte_count_o     = out_cnt_q;
  assign frame_end_o      = out_last_q;
  assign encoded_length_o = out_len_q;

endmodule

FILE: rtl/kre_seq.sv
// Run sequencer: tracks row position and the open run, stores literals, steps a
// closing run out one byte per cycle while the packer accepts. Depends on kre_pkg.
`timescale 1ns / 1ps

module kre_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kre_pkg::PIX_W-1:0]     pixel_i,
  input  logic [kre_pkg::CFG_W-1:0]     row_width_i,
  input  logic [kre_pkg::CFG_W-1:0]     row_count_i,
  input  logic [kre_pkg::KEY_W-1:0]     key_value_i,
  output kre_pkg::pack_cmd_t            cmd_o,
  input  kre_pkg::pack_sts_t            sts_i,
  output logic                          ram_we_o,
  output logic [kre_pkg::ADDR_W-1:0]    ram_wa_o,
  output logic [kre_pkg::PIX_W-1:0]     ram_wd_o,
  output logic                          ram_re_o,
  output logic [kre_pkg::ADDR_W-1:0]    ram_ra_o,
  input  logic [kre_pkg::PIX_W-1:0]     ram_rd_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_HDR,
    S_LIT,
    S_FLUSH
  } state_e;

  state_e                       state_q;
  logic [kre_pkg::RUN_W-1:0]    run_len_q;
  logic                         run_key_q;
  logic [kre_pkg::COL_W-1:0]    col_q;
  logic [kre_pkg::ROW_W-1:0]    row_q;
  logic [kre_pkg::PIX_W-1:0]    px_q;
  logic                         key_q;
  logic                         rowend_q;
  logic                         frame_q;
  logic                         second_q;
  logic [kre_pkg::RUN_W-1:0]    idx_q;

  logic [kre_pkg::CFG_W-1:0]    width;
  logic [kre_pkg::CFG_W-1:0]    rows;
  logic                         is_key;
  logic                         row_end;
  logic                         frame_hit;
  logic [kre_pkg::RUN_W-1:0]    len_inc;
  logic [kre_pkg::RUN_W-1:0]    idx_inc;
  logic                         lit_last;

  always_comb begin
    if (row_width_i == '0) begin
      width = kre_pkg::CFG_W'(1);
    end else if (row_width_i > kre_pkg::CFG_W'(kre_pkg::MAX_WIDTH)) begin
      width = kre_pkg::CFG_W'(kre_pkg::MAX_WIDTH);
    end else begin
      width = row_width_i;
    end
    if (row_count_i == '0) begin
      rows = kre_pkg::CFG_W'(1);
    end else if (row_count_i > kre_pkg::CFG_W'(kre_pkg::MAX_ROWS)) begin
      rows = kre_pkg::CFG_W'(kre_pkg::MAX_ROWS);
    end else begin
      rows = row_count_i;
    end
    is_key    = !key_value_i[kre_pkg::KEY_W-1] &&
                (pixel_i == key_value_i[kre_pkg::PIX_W-1:0]);
    row_end   = (kre_pkg::CFG_W'(col_q) + kre_pkg::CFG_W'(1)) >= width;
    frame_hit = (kre_pkg::CFG_W'(row_q) + kre_pkg::CFG_W'(1)) >= rows;
    len_inc   = run_len_q + kre_pkg::RUN_W'(1);
    idx_inc   = idx_q + kre_pkg::RUN_W'(1);
    lit_last  = (idx_inc == run_len_q);

    cmd_o    = '0;
    ram_re_o = 1'b0;
    ram_ra_o = '0;
    case (state_q)
      S_HDR: begin
        cmd_o.push = 1'b1;
        cmd_o.data = {run_key_q, run_len_q};
        cmd_o.mark = second_q && frame_q && run_key_q;
        // fetch the first literal while the length byte goes out
        ram_re_o   = sts_i.push_ok && !run_key_q;
      end
      S_LIT: begin
        cmd_o.push = 1'b1;
        cmd_o.data = ram_rd_i;
        cmd_o.mark = second_q && frame_q && lit_last;
        ram_re_o   = sts_i.push_ok && !lit_last;
        ram_ra_o   = idx_inc[kre_pkg::ADDR_W-1:0];
      end
      S_FLUSH: begin
        cmd_o.flush = 1'b1;
      end
      default: begin
      end
    endcase

    ram_we_o = (state_q == S_APPEND) && !key_q;
    ram_wa_o = run_len_q[kre_pkg::ADDR_W-1:0];
    ram_wd_o = px_q;
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      run_len_q <= '0;
      run_key_q <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
      px_q      <= '0;
      key_q     <= 1'b0;
      rowend_q  <= 1'b0;
      frame_q   <= 1'b0;
      second_q  <= 1'b0;
      idx_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            px_q     <= pixel_i;
            key_q    <= is_key;
            rowend_q <= row_end;
            frame_q  <= row_end && frame_hit;
            second_q <= 1'b0;
            if (row_end) begin
              col_q <= '0;
              row_q <= frame_hit ? '0 : row_q + kre_pkg::ROW_W'(1);
            end else begin
              col_q <= col_q + kre_pkg::COL_W'(1);
            end
            // class change closes the open run first
            if ((run_len_q != '0) && (is_key != run_key_q)) begin
              state_q <= S_HDR;
            end else begin
              state_q <= S_APPEND;
            end
          end
        end
        S_APPEND: begin
          if (run_len_q == '0) begin
            run_key_q <= key_q;
          end
          run_len_q <= len_inc;
          if ((len_inc >= kre_pkg::RUN_W'(kre_pkg::RUN_CAP)) || rowend_q) begin
            second_q <= 1'b1;
            state_q  <= S_HDR;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_HDR, S_LIT: begin
          if (sts_i.push_ok) begin
            if ((state_q == S_HDR && run_key_q) || (state_q == S_LIT && lit_last)) begin
              run_len_q <= '0;
              if (!second_q) begin
                state_q <= S_APPEND;
              end else if (frame_q) begin
                state_q <= S_FLUSH;
              end else begin
                state_q <= S_IDLE;
              end
            end else if (state_q == S_HDR) begin
              idx_q   <= '0;
              state_q <= S_LIT;
            end else begin
              idx_q <= idx_inc;
            end
          end
        end
        S_FLUSH: begin
          if (sts_i.flush_ok) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for keyed_rle_row_encoder: directed pixel table, then
// shaped random pixel streams checked word by word against an inline encoder.
// Depends on kre_pkg and the keyed_rle_row_encoder RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS  = 285;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;

  localparam logic [kre_pkg::IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [kre_pkg::PIX_W-1:0] KEY_FLAG  = 8'h80;

  typedef struct packed {
    logic [kre_pkg::WORD_W-1:0]  data;
    logic [kre_pkg::CNT_W-1:0]   count;
    logic                        last;
    logic [kre_pkg::TOTAL_W-1:0] total;
  } enc_word_t;

  typedef enum logic {STEP_PIXEL, STEP_CFG} step_e;

  typedef struct {
    step_e                      kind;
    logic [kre_pkg::IDX_W-1:0]  idx;
    logic [kre_pkg::CFG_W-1:0]  val;
    bit                         typed;
    enc_word_t                  want;
  } plan_row_t;

  typedef enum logic [1:0] {SEG_KEY, SEG_LITERAL, SEG_NOISE} seg_e;
  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_ALTERNATE} rx_mode_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [kre_pkg::PIX_W-1:0]   pixel_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [kre_pkg::WORD_W-1:0]  packed_bytes_o;
  logic [kre_pkg::CNT_W-1:0]   byte_count_o;
  logic                        frame_end_o;
  logic [kre_pkg::TOTAL_W-1:0] encoded_length_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [kre_pkg::IDX_W-1:0]   cfg_index_i;
  logic [kre_pkg::CFG_W-1:0]   cfg_data_i;

  keyed_rle_row_encoder uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pixel_i          (pixel_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .packed_bytes_o   (packed_bytes_o),
    .byte_count_o     (byte_count_o),
    .frame_end_o      (frame_end_o),
    .encoded_length_o (encoded_length_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Encoder shadow: registers and run/packing state
  logic [kre_pkg::CFG_W-1:0]   row_width_q;
  logic [kre_pkg::CFG_W-1:0]   row_count_q;
  logic [kre_pkg::KEY_W-1:0]   key_q;
  logic [kre_pkg::PIX_W-1:0]   literal_mem [kre_pkg::RUN_CAP];
  int unsigned                 run_len;
  bit                          run_on_key;
  int unsigned                 col_pos;
  int unsigned                 row_pos;
  logic [kre_pkg::WORD_W-1:0]  pack_acc;
  int unsigned                 pack_cnt;
  logic [kre_pkg::TOTAL_W-1:0] frame_bytes;

  enc_word_t new_words[$];
  enc_word_t expected_words[$];
  plan_row_t plan[$];

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_reqs = 0;
  seg_e        seg_kind;
  int unsigned seg_left = 0;
  logic [kre_pkg::PIX_W-1:0] seg_pixel;

  function automatic int unsigned clamp_dim(logic [kre_pkg::CFG_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : int'(v);
  endfunction

  task automatic write_back_regs(logic [kre_pkg::IDX_W-1:0] idx,
                                 logic [kre_pkg::CFG_W-1:0] val);
    case (idx)
      kre_pkg::REG_ROW_WIDTH: row_width_q = val;
      kre_pkg::REG_ROW_COUNT: row_count_q = val;
      kre_pkg::REG_KEY_VALUE: key_q = val[kre_pkg::KEY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic emit_word(int unsigned cnt, bit last);
    enc_word_t w;
    w.data  = pack_acc;
    w.count = kre_pkg::CNT_W'(cnt);
    w.last  = last;
    w.total = frame_bytes;
    new_words.push_back(w);
    pack_acc = '0;
    pack_cnt = 0;
  endtask

  task automatic pack_byte(logic [kre_pkg::PIX_W-1:0] b);
    pack_acc[8*pack_cnt +: 8] = b;
    pack_cnt++;
    frame_bytes++;
    if (pack_cnt >= kre_pkg::WORD_BYTES) emit_word(kre_pkg::WORD_BYTES, 1'b0);
  endtask

  task automatic close_run();
    if (run_len != 0) begin
      if (run_on_key) begin
        pack_byte(kre_pkg::PIX_W'(run_len) | KEY_FLAG);
      end else begin
        pack_byte(kre_pkg::PIX_W'(run_len));
        for (int i = 0; i < run_len; i++) pack_byte(literal_mem[i]);
      end
      run_len = 0;
    end
  endtask

  // Work out the words that one accepted pixel releases into new_words
  task automatic encode_pixel(logic [kre_pkg::PIX_W-1:0] p);
    int unsigned width;
    int unsigned rows;
    bit          hit;
    bit          row_done;
    enc_word_t   tail;
    width = clamp_dim(row_width_q, kre_pkg::MAX_WIDTH);
    rows  = clamp_dim(row_count_q, kre_pkg::MAX_ROWS);
    hit   = !key_q[kre_pkg::KEY_W-1] && (p == key_q[kre_pkg::PIX_W-1:0]);
    new_words.delete();
    if (run_len > 0 && hit != run_on_key) close_run();
    if (run_len == 0) run_on_key = hit;
    if (!hit && run_len < kre_pkg::RUN_CAP) literal_mem[run_len] = p;
    run_len++;
    row_done = (col_pos + 1) >= width;
    if (run_len >= kre_pkg::RUN_CAP || row_done) close_run();
    if (!row_done) begin
      col_pos++;
    end else begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rows) begin
        if (pack_cnt > 0) begin
          emit_word(pack_cnt, 1'b1);
        end else if (new_words.size() > 0) begin
          tail = new_words.pop_back();
          tail.last = 1'b1;
          new_words.push_back(tail);
        end
        row_pos     = 0;
        pack_acc    = '0;
        pack_cnt    = 0;
        frame_bytes = '0;
      end
    end
  endtask

  task automatic send_pixel(logic [kre_pkg::PIX_W-1:0] p, bit typed, enc_word_t want);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    pixel_i    <= p;
    do @(posedge clk_i); while (!in_ready_o);
    encode_pixel(p);
    if (typed) begin
      expected_words.push_back(want);
    end else begin
      foreach (new_words[i]) expected_words.push_back(new_words[i]);
    end
  endtask

  task automatic idle_sender(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Drop valid, wait for every pending word, then let the packer go quiet
  task automatic settle();
    idle_sender(1);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [kre_pkg::IDX_W-1:0] idx, logic [kre_pkg::CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    write_back_regs(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_cfg(logic [kre_pkg::IDX_W-1:0] idx, logic [kre_pkg::CFG_W-1:0] val);
    plan_row_t r;
    r.kind  = STEP_CFG;
    r.idx   = idx;
    r.val   = val;
    r.typed = 1'b0;
    r.want  = '0;
    plan.push_back(r);
  endtask

  task automatic add_pix(logic [kre_pkg::PIX_W-1:0] p);
    plan_row_t r;
    r.kind  = STEP_PIXEL;
    r.idx   = '0;
    r.val   = kre_pkg::CFG_W'(p);
    r.typed = 1'b0;
    r.want  = '0;
    plan.push_back(r);
  endtask

  task automatic add_pix_word(logic [kre_pkg::PIX_W-1:0] p, logic [kre_pkg::WORD_W-1:0] data,
                              int unsigned cnt, bit last, int unsigned total);
    plan_row_t r;
    r.kind       = STEP_PIXEL;
    r.idx        = '0;
    r.val        = kre_pkg::CFG_W'(p);
    r.typed      = 1'b1;
    r.want.data  = data;
    r.want.count = kre_pkg::CNT_W'(cnt);
    r.want.last  = last;
    r.want.total = kre_pkg::TOTAL_W'(total);
    plan.push_back(r);
  endtask

  // Segments of key runs, literal runs and mixed noise
  function automatic logic [kre_pkg::PIX_W-1:0] pick_pixel();
    logic [kre_pkg::PIX_W-1:0] p;
    bit                        has_key;
    has_key = !key_q[kre_pkg::KEY_W-1];
    if (seg_left == 0) begin
      seg_kind  = seg_e'($urandom_range(0, 2));
      seg_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 140)
                                              : $urandom_range(1, 10);
      seg_pixel = kre_pkg::PIX_W'($urandom_range(0, 255));
    end
    seg_left--;
    p = kre_pkg::PIX_W'($urandom_range(0, 255));
    case (seg_kind)
      SEG_KEY:     p = has_key ? key_q[kre_pkg::PIX_W-1:0] : seg_pixel;
      SEG_LITERAL: if (has_key && p == key_q[kre_pkg::PIX_W-1:0]) p = p ^ 8'h01;
      default:     if (has_key && $urandom_range(0, 3) == 0) p = key_q[kre_pkg::PIX_W-1:0];
    endcase
    return p;
  endfunction

  function automatic logic [kre_pkg::CFG_W-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return kre_pkg::CFG_W'(1);
    if (r <= 5) return kre_pkg::CFG_W'($urandom_range(2, 12));
    if (r <= 7) return kre_pkg::CFG_W'($urandom_range(13, 160));
    if (r == 8) return kre_pkg::CFG_W'(kre_pkg::MAX_WIDTH);
    return kre_pkg::CFG_W'($urandom_range(kre_pkg::MAX_WIDTH + 1, 8191));
  endfunction

  function automatic logic [kre_pkg::CFG_W-1:0] pick_rows();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r <= 3) return kre_pkg::CFG_W'(1);
    if (r <= 7) return kre_pkg::CFG_W'($urandom_range(2, 5));
    if (r == 8) return kre_pkg::CFG_W'(kre_pkg::MAX_ROWS);
    return kre_pkg::CFG_W'($urandom_range(kre_pkg::MAX_ROWS + 1, 8191));
  endfunction

  function automatic logic [kre_pkg::CFG_W-1:0] pick_key();
    logic [kre_pkg::CFG_W-1:0] v;
    int unsigned               r;
    v = kre_pkg::CFG_W'($urandom());
    r = $urandom_range(0, 7);
    if (r <= 1) v[kre_pkg::KEY_W-1:0] = kre_pkg::KEY_VALUE_RST;
    else if (r == 2) v[kre_pkg::KEY_W-1] = 1'b1;
    else v[kre_pkg::KEY_W-1] = 1'b0;
    return v;
  endfunction

  // Receiver: stall patterns, plus one long hold-off on request
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned holds_done;
    bit          toggle;
    out_ready_i = 1'b0;
    mode        = RX_ALWAYS;
    mode_left   = 0;
    holds_done  = 0;
    toggle      = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_done) begin
        out_ready_i <= 1'b0;
        for (int k = 1; k < HOLD_CYCLES; k++) @(negedge clk_i);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        toggle = !toggle;
        case (mode)
          RX_ALWAYS:   out_ready_i <= 1'b1;
          RX_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
          RX_SPARSE:   out_ready_i <= ($urandom_range(0, 3) == 0);
          default:     out_ready_i <= toggle;
        endcase
      end
    end
  end

  enc_word_t seen_word;
  enc_word_t want_word;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_word.data  = packed_bytes_o;
      seen_word.count = byte_count_o;
      seen_word.last  = frame_end_o;
      seen_word.total = encoded_length_o;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected word data=%h count=%0d end=%b length=%0d", $realtime,
                   seen_word.data, seen_word.count, seen_word.last, seen_word.total);
      end else begin
        want_word = expected_words.pop_front();
        if (seen_word !== want_word) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: word mismatch", $realtime);
            $display("  expected data=%h count=%0d end=%b length=%0d", want_word.data,
                     want_word.count, want_word.last, want_word.total);
            $display("  actual   data=%h count=%0d end=%b length=%0d", seen_word.data,
                     seen_word.count, seen_word.last, seen_word.total);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned items_sent;
    int unsigned phase_items;
    int unsigned burst_left;
    int unsigned gap_max;
    bit          first_phase;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    pixel_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;

    row_width_q = kre_pkg::ROW_WIDTH_RST;
    row_count_q = kre_pkg::ROW_COUNT_RST;
    key_q       = kre_pkg::KEY_VALUE_RST;
    run_len     = 0;
    run_on_key  = 1'b0;
    col_pos     = 0;
    row_pos     = 0;
    pack_acc    = '0;
    pack_cnt    = 0;
    frame_bytes = '0;

    // One-pixel frames straight out of reset, then key handling
    add_pix_word(8'h00, 64'h0001, 2, 1'b1, 2);
    add_pix_word(8'hFF, 64'hFF01, 2, 1'b1, 2);
    add_cfg(kre_pkg::REG_KEY_VALUE, 13'h00FF);
    add_pix_word(8'hFF, 64'h0081, 1, 1'b1, 1);
    add_pix_word(8'hFE, 64'hFE01, 2, 1'b1, 2);
    add_cfg(kre_pkg::REG_KEY_VALUE, 13'h0000);
    add_pix_word(8'h00, 64'h0081, 1, 1'b1, 1);
    // negative key with junk above bit 8: nothing matches
    add_cfg(kre_pkg::REG_KEY_VALUE, 13'h1F55);
    add_pix_word(8'h55, 64'h5501, 2, 1'b1, 2);
    // zero width and count act as one
    add_cfg(kre_pkg::REG_ROW_WIDTH, 13'd0);
    add_cfg(kre_pkg::REG_ROW_COUNT, 13'd0);
    add_pix_word(8'h12, 64'h1201, 2, 1'b1, 2);
    add_cfg(REG_SPARE, 13'h1FFF);
    add_pix_word(8'h80, 64'h8001, 2, 1'b1, 2);
    // seven literals fill exactly one word that also ends the frame
    add_cfg(kre_pkg::REG_ROW_WIDTH, 13'd7);
    add_pix(8'h11);
    add_pix(8'h22);
    add_pix(8'h33);
    add_pix(8'h44);
    add_pix(8'h55);
    add_pix(8'h66);
    add_pix_word(8'h77, 64'h7766554433221107, 8, 1'b1, 8);
    // two-row frame mixing key and literal runs
    add_cfg(kre_pkg::REG_ROW_WIDTH, 13'd4);
    add_cfg(kre_pkg::REG_ROW_COUNT, 13'd2);
    add_cfg(kre_pkg::REG_KEY_VALUE, 13'h00AA);
    add_pix(8'hAA);
    add_pix(8'hAA);
    add_pix(8'h33);
    add_pix(8'hAA);
    add_pix(8'h01);
    add_pix(8'h02);
    add_pix(8'hAA);
    add_pix(8'h03);
    // oversize bounds saturate; the row stays open into the random part
    add_cfg(kre_pkg::REG_ROW_WIDTH, 13'd8191);
    add_cfg(kre_pkg::REG_ROW_COUNT, 13'd8191);
    add_cfg(kre_pkg::REG_KEY_VALUE, 13'h01FF);
    add_pix(8'h5A);
    add_pix(8'hA5);

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_pixel(plan[i].val[kre_pkg::PIX_W-1:0], plan[i].typed, plan[i].want);
      end
    end

    items_sent  = 0;
    first_phase = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      settle();
      if (first_phase) begin
        // long literal stream against a stalled receiver
        write_reg(kre_pkg::REG_ROW_WIDTH, kre_pkg::CFG_W'(kre_pkg::MAX_WIDTH));
        write_reg(kre_pkg::REG_ROW_COUNT, 13'd1);
        write_reg(kre_pkg::REG_KEY_VALUE, pick_key());
        seg_kind    = SEG_LITERAL;
        seg_left    = 130;
        phase_items = 140;
        gap_max     = 0;
      end else begin
        write_reg(kre_pkg::REG_ROW_WIDTH, pick_width());
        write_reg(kre_pkg::REG_ROW_COUNT, pick_rows());
        write_reg(kre_pkg::REG_KEY_VALUE, pick_key());
        if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, kre_pkg::CFG_W'($urandom()));
        phase_items = $urandom_range(15, 45);
        gap_max     = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      burst_left = $urandom_range(1, 20);
      for (int n = 0; n < phase_items && items_sent < RANDOM_ITEMS; n++) begin
        if (first_phase && n == 10) hold_reqs++;
        send_pixel(pick_pixel(), 1'b0, '0);
        items_sent++;
        if (!first_phase && $urandom_range(0, 40) == 0) settle();
        burst_left--;
        if (burst_left == 0) begin
          if (gap_max > 0) idle_sender($urandom_range(1, gap_max));
          burst_left = $urandom_range(1, 20);
        end
      end
      first_phase = 1'b0;
    end

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: keyed_rle_row_encoder.f
rtl/kre_pkg.sv
rtl/kre_ram.sv
rtl/kre_pack.sv
rtl/kre_seq.sv
rtl/keyed_rle_row_encoder.sv
sim/testbench.sv
